### rtl/core/ctc_pkg.sv
package ctc_pkg;

   localparam int MAX_WORD_DEF = 100;
   localparam int KW_NUM_DEF   = 13;
   localparam int KW_SLOTS     = 32;
   localparam int QUEUE_DEPTH  = 4;
   localparam int QUEUE_PTR_W  = $clog2(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      CLS_KEYWORD  = 3'd0,
      CLS_CONSTANT = 3'd1,
      CLS_IDENT    = 3'd2,
      CLS_UNKNOWN  = 3'd3,
      CLS_OPERATOR = 3'd4,
      CLS_PUNCT    = 3'd5,
      CLS_TOO_LONG = 3'd6
   } token_class_type;

   typedef struct packed {
      logic       action;
      logic [7:0] byte_in;
   } req_type;

   typedef struct packed {
      logic [2:0] token_class;
      logic [6:0] token_length;
      logic [3:0] keyword_index;
      logic [7:0] symbol;
      logic       last_of_run;
   } rsp_type;

   typedef struct packed {
      rsp_type first_rsp;
      rsp_type second_rsp;
      logic    two_rsp;
   } entry_type;

   function automatic logic [3:0] kw_len(input logic [4:0] idx);
      logic [3:0] len;
      unique case (idx)
         5'd0:    len = 4'd3;
         5'd1:    len = 4'd5;
         5'd2:    len = 4'd4;
         5'd3:    len = 4'd6;
         5'd4:    len = 4'd2;
         5'd5:    len = 4'd4;
         5'd6:    len = 4'd5;
         5'd7:    len = 4'd3;
         5'd8:    len = 4'd6;
         5'd9:    len = 4'd4;
         5'd10:   len = 4'd5;
         5'd11:   len = 4'd8;
         5'd12:   len = 4'd2;
         default: len = 4'd0;
      endcase
      return len;
   endfunction

   // The first character of a keyword sits in the highest used byte.
   function automatic logic [63:0] kw_text(input logic [4:0] idx);
      logic [63:0] txt;
      unique case (idx)
         5'd0:    txt = 64'("int");
         5'd1:    txt = 64'("float");
         5'd2:    txt = 64'("char");
         5'd3:    txt = 64'("double");
         5'd4:    txt = 64'("if");
         5'd5:    txt = 64'("else");
         5'd6:    txt = 64'("while");
         5'd7:    txt = 64'("for");
         5'd8:    txt = 64'("return");
         5'd9:    txt = 64'("void");
         5'd10:   txt = 64'("break");
         5'd11:   txt = 64'("continue");
         5'd12:   txt = 64'("do");
         default: txt = 64'd0;
      endcase
      return txt;
   endfunction

   function automatic logic [7:0] kw_char(input logic [4:0] idx, input logic [2:0] pos);
      logic [3:0]  len;
      logic [2:0]  sel;
      logic [63:0] txt;
      len = kw_len(idx);
      sel = 3'(len - 4'd1 - {1'b0, pos});
      txt = kw_text(idx) >> {sel, 3'b000};
      return txt[7:0];
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic logic is_operator(input logic [7:0] c);
      return (c == "+") || (c == "-") || (c == "*") || (c == "/") ||
             (c == "%") || (c == "=") || (c == "<") || (c == ">") ||
             (c == "!") || (c == "&") || (c == "|") || (c == "^");
   endfunction

   function automatic logic is_punct(input logic [7:0] c);
      return (c == ";") || (c == ",") || (c == "(") || (c == ")") ||
             (c == "{") || (c == "}") || (c == "[") || (c == "]");
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

endpackage

### rtl/core/ctc_front.sv
module ctc_front #(
   parameter int MAX_WORD = 100,
   parameter int KW_NUM   = 13
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  ctc_pkg::req_type   item,
   output ctc_pkg::entry_type entry,
   output logic               entry_valid
);
   import ctc_pkg::*;

   localparam int LW = $clog2(MAX_WORD);

   logic [LW-1:0]     len_ff, len_in;
   logic [KW_NUM-1:0] cand_ff, cand_in, cand_add;
   logic              dig_ff, dig_in;
   logic              idok_ff, idok_in;

   logic [7:0]    c;
   logic          has_word;
   logic          found;
   logic [4:0]    kw_idx;
   logic [LW-1:0] len_plus;
   logic [LW+6:0] len_ext, len_plus_ext;
   rsp_type       word_rsp, sym_rsp, long_rsp;

   assign c            = item.byte_in;
   assign has_word     = (len_ff != '0);
   assign len_plus     = len_ff + 1'b1;
   assign len_ext      = (LW+7)'(len_ff);
   assign len_plus_ext = (LW+7)'(len_plus);

   always_comb begin
      found  = 1'b0;
      kw_idx = 5'd0;
      for (int i = KW_NUM - 1; i >= 0; i--) begin
         if (cand_ff[i] && ((LW+4)'(kw_len(5'(i))) == (LW+4)'(len_ff))) begin
            found  = 1'b1;
            kw_idx = 5'(i);
         end
      end
   end

   always_comb begin
      for (int i = 0; i < KW_NUM; i++) begin
         cand_add[i] = cand_ff[i] &&
                       ((LW+4)'(len_ff) < (LW+4)'(kw_len(5'(i)))) &&
                       (kw_char(5'(i), len_ff[2:0]) == c);
      end
   end

   always_comb begin
      word_rsp               = '0;
      word_rsp.token_length  = len_ext[6:0];
      word_rsp.last_of_run   = 1'b1;
      if (found) begin
         word_rsp.token_class   = CLS_KEYWORD;
         word_rsp.keyword_index = kw_idx[3:0];
      end else if (dig_ff) begin
         word_rsp.token_class = CLS_CONSTANT;
      end else if (idok_ff) begin
         word_rsp.token_class = CLS_IDENT;
      end else begin
         word_rsp.token_class = CLS_UNKNOWN;
      end

      sym_rsp              = '0;
      sym_rsp.token_class  = is_operator(c) ? CLS_OPERATOR : CLS_PUNCT;
      sym_rsp.token_length = 7'd1;
      sym_rsp.symbol       = c;
      sym_rsp.last_of_run  = 1'b1;

      long_rsp              = '0;
      long_rsp.token_class  = CLS_TOO_LONG;
      long_rsp.token_length = len_plus_ext[6:0];
      long_rsp.last_of_run  = 1'b1;
   end

   always_comb begin
      len_in      = len_ff;
      cand_in     = cand_ff;
      dig_in      = dig_ff;
      idok_in     = idok_ff;
      entry       = '0;
      entry_valid = 1'b0;
      if (accept) begin
         if (item.action || is_space(c)) begin
            entry.first_rsp = word_rsp;
            entry_valid     = has_word;
            len_in          = '0;
            cand_in         = '1;
            dig_in          = 1'b1;
            idok_in         = 1'b1;
         end else if (is_operator(c) || is_punct(c)) begin
            if (has_word) begin
               entry.first_rsp             = word_rsp;
               entry.first_rsp.last_of_run = 1'b0;
               entry.second_rsp            = sym_rsp;
               entry.two_rsp               = 1'b1;
            end else begin
               entry.first_rsp = sym_rsp;
            end
            entry_valid = 1'b1;
            len_in      = '0;
            cand_in     = '1;
            dig_in      = 1'b1;
            idok_in     = 1'b1;
         end else if (len_ff == LW'(MAX_WORD - 2)) begin
            entry.first_rsp = long_rsp;
            entry_valid     = 1'b1;
            len_in          = '0;
            cand_in         = '1;
            dig_in          = 1'b1;
            idok_in         = 1'b1;
         end else begin
            len_in  = len_plus;
            cand_in = cand_add;
            dig_in  = dig_ff && is_digit(c);
            if (!has_word) begin
               idok_in = is_alpha(c) || (c == "_");
            end else begin
               idok_in = idok_ff && (is_alpha(c) || is_digit(c) || (c == "_"));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         cand_ff <= '1;
         dig_ff  <= 1'b1;
         idok_ff <= 1'b1;
      end else begin
         len_ff  <= len_in;
         cand_ff <= cand_in;
         dig_ff  <= dig_in;
         idok_ff <= idok_in;
      end
   end

endmodule

### rtl/core/ctc_back.sv
module ctc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  ctc_pkg::entry_type wr_entry,
   output logic               full,
   output logic               empty,
   input  logic               pop,
   output ctc_pkg::rsp_type   rsp_item
);
   import ctc_pkg::*;

   entry_type              mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   half_ff, half_in;
   entry_type              head;
   logic                   take, deq;

   assign head     = mem_ff[rd_ptr_ff];
   assign full     = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign rsp_item = half_ff ? head.second_rsp : head.first_rsp;
   assign take     = pop && !empty;
   assign deq      = take && (half_ff || !head.two_rsp);

   always_comb begin
      wr_ptr_in = wr_en ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = deq ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (QUEUE_PTR_W+1)'(wr_en) - (QUEUE_PTR_W+1)'(deq);
      half_in   = half_ff;
      if (deq) begin
         half_in = 1'b0;
      end else if (take) begin
         half_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
         half_ff   <= 1'b0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
         half_ff   <= half_in;
      end
   end

endmodule

### rtl/core/c_token_classifier_top.sv
// A result is queued as its item is accepted and shows once older ones are popped.
// Throughput: one item per cycle while full is low; an item that causes two
// results holds the result side for two pops, and the four-entry queue between
// the classifier and the result side sets how far input may run ahead of the pops.
// Reset is synchronous and active high; it empties the queue and restarts the word.
module c_token_classifier_top #(
   parameter int MAX_WORD = ctc_pkg::MAX_WORD_DEF,
   parameter int KW_NUM   = ctc_pkg::KW_NUM_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  ctc_pkg::req_type req_item,
   output logic             empty,
   input  logic             pop,
   output ctc_pkg::rsp_type rsp_item
);
   import ctc_pkg::*;

   entry_type entry;
   logic      entry_valid;
   logic      accept;

   assign accept = push && !full;

   ctc_front #(
      .MAX_WORD (MAX_WORD),
      .KW_NUM   (KW_NUM)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .item        (req_item),
      .entry       (entry),
      .entry_valid (entry_valid)
   );

   ctc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (entry_valid),
      .wr_entry (entry),
      .full     (full),
      .empty    (empty),
      .pop      (pop),
      .rsp_item (rsp_item)
   );

endmodule

### rtl/core/ctc_checker.sv
module ctc_checker (
   input logic             clock,
   input logic             reset,
   input logic             push,
   input logic             full,
   input ctc_pkg::req_type req_item,
   input logic             empty,
   input logic             pop,
   input ctc_pkg::rsp_type rsp_item
);
   import ctc_pkg::*;

   logic unused_req;
   assign unused_req = ^req_item;

   // Results appear only after an accepted item.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(empty) && !$past(push && !full)) |-> empty)
      else $error("result appeared without an accepted item");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> empty)
      else $error("queue not empty after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $past(!empty && !pop)) |-> (!empty && $stable(rsp_item)))
      else $error("waiting result changed");

   a_class_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_item.token_class != 3'd7 && rsp_item.token_length != 7'd0))
      else $error("bad class or zero length");

   a_word_symbol: assert property (@(posedge clock) disable iff (reset)
      (!empty && (rsp_item.token_class == CLS_KEYWORD ||
                  rsp_item.token_class == CLS_CONSTANT ||
                  rsp_item.token_class == CLS_IDENT ||
                  rsp_item.token_class == CLS_UNKNOWN ||
                  rsp_item.token_class == CLS_TOO_LONG)) |-> (rsp_item.symbol == 8'd0))
      else $error("word token carries a symbol");

endmodule

bind c_token_classifier_top ctc_checker u_ctc_checker (.*);
